### design/assert_macros.svh
// Shared assertion macros for the fold unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/enfu_pkg.sv
package enfu_pkg;

  localparam int unsigned OpW = 4;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_MOD  = 4'd4,
    OP_EQ   = 4'd5,
    OP_NE   = 4'd6,
    OP_LT   = 4'd7,
    OP_LE   = 4'd8,
    OP_GT   = 4'd9,
    OP_GE   = 4'd10,
    OP_LAND = 4'd11,
    OP_LOR  = 4'd12,
    OP_NEG  = 4'd13,
    OP_LNOT = 4'd14,
    OP_OTHER = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_LIT   = 2'd1,
    ACT_LEFT  = 2'd2,
    ACT_RIGHT = 2'd3
  } act_e;

  localparam int unsigned DataW = 32;

  typedef struct packed {
    logic [3:0]              opcode;
    logic                    left_is_literal;
    logic signed [DataW-1:0] left_value;
    logic                    right_is_literal;
    logic signed [DataW-1:0] right_value;
  } node_t;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [DataW-1:0] literal_value;
  } fold_t;

  // Decision made in the front stage; the arithmetic tail fills in the value.
  typedef struct packed {
    logic [1:0] action;
    logic [2:0] src;
  } decide_t;

  typedef enum logic [2:0] {
    SRC_ZERO = 3'd0,
    SRC_FLAG = 3'd1,
    SRC_ADD  = 3'd2,
    SRC_MUL  = 3'd3,
    SRC_QUO  = 3'd4,
    SRC_REM  = 3'd5
  } src_e;

endpackage

### design/enfu_divider.sv
// Pipelined restoring divider on magnitudes: one quotient bit per stage.
module enfu_divider #(
  parameter int unsigned Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             valid_o,
  output logic [Width-1:0] quotient_o,
  output logic [Width-1:0] remainder_o
);

  for (genvar s = 0; s < Width; s++) begin : g_stage
    logic             vld_in;
    logic [Width-1:0] rem_in;
    logic [Width-1:0] quo_in;
    logic [Width-1:0] dvs_in;
    logic [Width:0]   trial;
    logic [Width-1:0] rem_d;
    logic [Width-1:0] quo_d;
    logic             vld_q;
    logic [Width-1:0] rem_q;
    logic [Width-1:0] quo_q;
    logic [Width-1:0] dvs_q;

    if (s == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = '0;
      assign quo_in = dividend_i;
      assign dvs_in = divisor_i;
    end else begin : g_next
      assign vld_in = g_stage[s-1].vld_q;
      assign rem_in = g_stage[s-1].rem_q;
      assign quo_in = g_stage[s-1].quo_q;
      assign dvs_in = g_stage[s-1].dvs_q;
    end

    always_comb begin
      trial = {rem_in, quo_in[Width-1]} - {1'b0, dvs_in};
      if (!trial[Width]) begin
        rem_d = trial[Width-1:0];
        quo_d = {quo_in[Width-2:0], 1'b1};
      end else begin
        rem_d = {rem_in[Width-2:0], quo_in[Width-1]};
        quo_d = {quo_in[Width-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      dvs_q <= dvs_in;
    end
  end

  assign valid_o     = g_stage[Width-1].vld_q;
  assign quotient_o  = g_stage[Width-1].quo_q;
  assign remainder_o = g_stage[Width-1].rem_q;

endmodule

### design/enfu_decide.sv
// Front stage: classifies the node and computes the cheap results.
module enfu_decide #(
  parameter int unsigned Width = 32
) (
  input  logic [3:0]       opcode_i,
  input  logic             llit_i,
  input  logic [Width-1:0] l_i,
  input  logic             rlit_i,
  input  logic [Width-1:0] r_i,
  output enfu_pkg::decide_t dec_o,
  output logic             flag_o
);

  logic lz, rz, r1, l1, both, lt, gt, eqv;

  always_comb begin
    lz   = (l_i == '0);
    rz   = (r_i == '0);
    l1   = (l_i == Width'(1));
    r1   = (r_i == Width'(1));
    both = llit_i && rlit_i;
    eqv  = (l_i == r_i);
    lt   = ($signed(l_i) < $signed(r_i));
    gt   = ($signed(r_i) < $signed(l_i));
    dec_o.action = enfu_pkg::ACT_NONE;
    dec_o.src    = enfu_pkg::SRC_ZERO;
    flag_o = 1'b0;
    case (opcode_i)
      enfu_pkg::OP_EQ:   flag_o = eqv;
      enfu_pkg::OP_NE:   flag_o = !eqv;
      enfu_pkg::OP_LT:   flag_o = lt;
      enfu_pkg::OP_LE:   flag_o = !gt;
      enfu_pkg::OP_GT:   flag_o = gt;
      enfu_pkg::OP_GE:   flag_o = !lt;
      enfu_pkg::OP_LAND: flag_o = !lz && !rz;
      enfu_pkg::OP_LOR:  flag_o = !lz || !rz;
      enfu_pkg::OP_LNOT: flag_o = lz;
      default:           flag_o = 1'b0;
    endcase

    if (opcode_i == enfu_pkg::OP_NEG || opcode_i == enfu_pkg::OP_LNOT) begin
      if (llit_i) begin
        dec_o.action = enfu_pkg::ACT_LIT;
        dec_o.src    = (opcode_i == enfu_pkg::OP_NEG) ? enfu_pkg::SRC_ADD
                                                      : enfu_pkg::SRC_FLAG;
      end
    end else if (opcode_i != enfu_pkg::OP_OTHER) begin
      if (both && !((opcode_i == enfu_pkg::OP_DIV || opcode_i == enfu_pkg::OP_MOD) && rz))
      begin
        dec_o.action = enfu_pkg::ACT_LIT;
        case (opcode_i)
          enfu_pkg::OP_ADD, enfu_pkg::OP_SUB: dec_o.src = enfu_pkg::SRC_ADD;
          enfu_pkg::OP_MUL: dec_o.src = enfu_pkg::SRC_MUL;
          enfu_pkg::OP_DIV: dec_o.src = enfu_pkg::SRC_QUO;
          enfu_pkg::OP_MOD: dec_o.src = enfu_pkg::SRC_REM;
          default:          dec_o.src = enfu_pkg::SRC_FLAG;
        endcase
      end else if (rlit_i && (opcode_i == enfu_pkg::OP_ADD || opcode_i == enfu_pkg::OP_SUB)
                   && rz) begin
        dec_o.action = enfu_pkg::ACT_LEFT;
      end else if (rlit_i && (opcode_i == enfu_pkg::OP_MUL || opcode_i == enfu_pkg::OP_DIV)
                   && r1) begin
        dec_o.action = enfu_pkg::ACT_LEFT;
      end else if (rlit_i && opcode_i == enfu_pkg::OP_MUL && rz) begin
        dec_o.action = enfu_pkg::ACT_LIT;
      end else if (llit_i && opcode_i == enfu_pkg::OP_ADD && lz) begin
        dec_o.action = enfu_pkg::ACT_RIGHT;
      end else if (llit_i && opcode_i == enfu_pkg::OP_MUL && lz) begin
        dec_o.action = enfu_pkg::ACT_LIT;
      end else if (llit_i && opcode_i == enfu_pkg::OP_MUL && l1) begin
        dec_o.action = enfu_pkg::ACT_RIGHT;
      end
    end
  end

endmodule

### design/expression_node_fold_unit.sv
// Channel   | Ports                           | Handshake
// node in   | start_i, node_i, busy_o         | transfer when start_i && !busy_o
// fold out  | done_o, fold_o                  | one-cycle strobe, never stalled
//
// One node can enter on every cycle, so busy_o is always low outside reset.
// The latency is set by the divider, which resolves one quotient bit a stage;
// the other results ride a matching delay line beside it.
// Reset clears all valid bits; no result is in flight afterwards.
module expression_node_fold_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  enfu_pkg::node_t node_i,
  output logic            busy_o,
  output logic            done_o,
  output enfu_pkg::fold_t fold_o
);
  `include "assert_macros.svh"

  localparam int unsigned W = enfu_pkg::DataW;
  localparam int unsigned Lat = W;

  logic [W-1:0] l_in, r_in;
  logic         accept;
  enfu_pkg::decide_t dec;
  logic         flag;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign l_in = W'(node_i.left_value);
  assign r_in = W'(node_i.right_value);

  enfu_decide #(.Width(W)) u_decide (
    .opcode_i (node_i.opcode),
    .llit_i   (node_i.left_is_literal),
    .l_i      (l_in),
    .rlit_i   (node_i.right_is_literal),
    .r_i      (r_in),
    .dec_o    (dec),
    .flag_o   (flag)
  );

  // Stage 1: register inputs and the decision.
  logic              v1_q;
  enfu_pkg::decide_t dec1_q;
  logic              flag1_q, neg1_q, sub1_q;
  logic [W-1:0]      l1_q, r1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    dec1_q  <= dec;
    flag1_q <= flag;
    neg1_q  <= (node_i.opcode == enfu_pkg::OP_NEG);
    sub1_q  <= (node_i.opcode == enfu_pkg::OP_SUB);
    l1_q    <= l_in;
    r1_q    <= r_in;
  end

  // Stage 2: add/sub/negate, multiply and the divider's magnitudes.
  logic [W-1:0] addv, absl, absr;
  logic         sq, sr;
  always_comb begin
    if (neg1_q) begin
      addv = W'(0) - l1_q;
    end else if (sub1_q) begin
      addv = l1_q - r1_q;
    end else begin
      addv = l1_q + r1_q;
    end
    absl = l1_q[W-1] ? (W'(0) - l1_q) : l1_q;
    absr = r1_q[W-1] ? (W'(0) - r1_q) : r1_q;
    sq   = l1_q[W-1] ^ r1_q[W-1];
    sr   = l1_q[W-1];
  end

  logic         v2_q;
  enfu_pkg::decide_t dec2_q;
  logic         flag2_q, sq2_q, sr2_q;
  logic [W-1:0] add2_q, mul2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dec2_q  <= dec1_q;
    flag2_q <= flag1_q;
    sq2_q   <= sq;
    sr2_q   <= sr;
    add2_q  <= addv;
    mul2_q  <= W'(l1_q * r1_q);
  end

  logic         dv_valid;
  logic [W-1:0] quo, rem;
  enfu_divider #(.Width(W)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v1_q),
    .dividend_i  (absl),
    .divisor_i   (absr),
    .valid_o     (dv_valid),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  // Side data delayed to match the divider.
  typedef struct packed {
    enfu_pkg::decide_t dec;
    logic              flag;
    logic              sq;
    logic              sr;
    logic [W-1:0]      add;
    logic [W-1:0]      mul;
  } side_t;

  side_t side_q [Lat-1];
  always_ff @(posedge clk_i) begin
    side_q[0] <= '{dec: dec2_q, flag: flag2_q, sq: sq2_q, sr: sr2_q,
                   add: add2_q, mul: mul2_q};
    for (int i = 1; i < Lat - 1; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  side_t s;
  logic [W-1:0] val;
  assign s = side_q[Lat-2];

  always_comb begin
    case (s.dec.src)
      enfu_pkg::SRC_FLAG: val = W'(s.flag);
      enfu_pkg::SRC_ADD:  val = s.add;
      enfu_pkg::SRC_MUL:  val = s.mul;
      enfu_pkg::SRC_QUO:  val = s.sq ? (W'(0) - quo) : quo;
      enfu_pkg::SRC_REM:  val = s.sr ? (W'(0) - rem) : rem;
      default:            val = '0;
    endcase
    if (s.dec.action != enfu_pkg::ACT_LIT) begin
      val = '0;
    end
  end

  logic            done_q;
  enfu_pkg::fold_t fold_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    fold_q.action        <= s.dec.action;
    fold_q.literal_value <= enfu_pkg::DataW'($signed(val));
  end

  assign done_o = done_q;
  assign fold_o = fold_q;

  `ASSERT_IMPL(a_never_busy, clk_i, rst_ni, 1'b1, !busy_o, "fold unit reported busy")
  `ASSERT_NEXT(a_v1_follows, clk_i, rst_ni, accept, v1_q, "accepted node not staged")
  `ASSERT_IMPL(a_lit_only, clk_i, rst_ni, done_o && fold_o.action != enfu_pkg::ACT_LIT, fold_o.literal_value == '0, "nonzero literal on non-literal action")

endmodule
